// ----- rtl/core/ffia_pkg.sv -----
// ----------------------------------------------------------------------------
// ffia_pkg: shared types and constants of the first-fit arena layout block
// Sizes of the buffer table and the event sums, the result status codes,
// the stored table entry and the alignment helper.
// ----------------------------------------------------------------------------
package ffia_pkg;

  localparam int MAX_BUFFERS = 64;
  localparam int MAX_EVENTS  = 64;
  // ALIGN_BYTES must be a power of two.
  localparam int ALIGN_BYTES = 64;
  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);

  localparam int BUF_AW = $clog2(MAX_BUFFERS);
  localparam int BUF_CW = $clog2(MAX_BUFFERS + 1);
  localparam int EV_AW  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int EV_CW  = $clog2(MAX_EVENTS + 1);

  localparam int EVENT_CFG_W = 7;
  localparam logic [EVENT_CFG_W-1:0] EVENT_COUNT_RST = 7'd35;

  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ALIAS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] end_addr;
    logic [5:0]  first_ev;
    logic [5:0]  last_ev;
    logic        is_alias;
  } entry_t;

  // Round a byte count up to the alignment; the result may need 33 bits.
  function automatic logic [32:0] aligned_len(input logic [31:0] n);
    logic [32:0] sum;
    sum = {1'b0, n} + 33'(ALIGN_BYTES - 1);
    return (sum >> ALIGN_SHIFT) << ALIGN_SHIFT;
  endfunction

endpackage

// ----- rtl/core/ffia_in_if.sv -----
// ----------------------------------------------------------------------------
// ffia_in_if: buffer descriptor channel
// Valid/ready channel that carries one buffer description per word.
// ----------------------------------------------------------------------------
interface ffia_in_if;
  logic        valid;
  logic        ready;
  logic        start_schedule;
  logic [31:0] size_bytes;
  logic [5:0]  first_event;
  logic [5:0]  last_event;
  logic        is_alias;
  logic [5:0]  alias_index;

  modport source (
    output valid, start_schedule, size_bytes, first_event, last_event,
           is_alias, alias_index,
    input  ready
  );
  modport sink (
    input  valid, start_schedule, size_bytes, first_event, last_event,
           is_alias, alias_index,
    output ready
  );
endinterface

// ----- rtl/core/ffia_out_if.sv -----
// ----------------------------------------------------------------------------
// ffia_out_if: placement result channel
// Valid/ready channel that carries one placement result per word.
// ----------------------------------------------------------------------------
interface ffia_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] offset;
  logic [31:0] arena_top;
  logic [31:0] live_peak;
  logic [1:0]  status;

  modport source (
    output valid, offset, arena_top, live_peak, status,
    input  ready
  );
  modport sink (
    input  valid, offset, arena_top, live_peak, status,
    output ready
  );
endinterface

// ----- rtl/core/ffia_ram.sv -----
// ----------------------------------------------------------------------------
// ffia_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/first_fit_interval_arena_layout.sv -----
// ----------------------------------------------------------------------------
// first_fit_interval_arena_layout: first-fit buffer offset assignment
// Steps: a rejected word goes from IDLE through SWEEP to DONE, an alias
// through ALIAS, SWEEP and DONE, a word to place through SCAN, a first-fit
// scan over the stored entries, then SWEEP and DONE.
// One word at a time; the next is taken once its result is in the output register.
// Reset: synchronous, active low; empty schedule, event_count back to 35.
// ----------------------------------------------------------------------------
module first_fit_interval_arena_layout (
  input  logic                                clk,
  input  logic                                rst_n,
  ffia_in_if.sink                             in_ch,
  ffia_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [ffia_pkg::EVENT_CFG_W-1:0]    cfg_wdata
);

  import ffia_pkg::*;

  // Sequencer states. IDLE takes a word, ALIAS waits for the aliased entry,
  // SCAN runs the first-fit search, SWEEP updates the event sums and finds
  // the peak, DONE hands the result to the output register.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIAS = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Control and schedule state.
  logic [2:0]             state_r, state_nxt;
  logic [BUF_CW-1:0]      cnt_r, cnt_nxt;
  logic [31:0]            arena_r, arena_nxt;
  logic [31:0]            peak_r, peak_nxt;
  logic [EVENT_CFG_W-1:0] event_count_r, event_count_nxt;
  logic [MAX_EVENTS-1:0]  sum_vld_r, sum_vld_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic                   pev_vld_r, pev_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Current word and working values.
  logic [31:0]            size_r, size_nxt;
  logic [5:0]             fe_r, fe_nxt;
  logic [5:0]             le_r, le_nxt;
  logic [32:0]            need_r, need_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [31:0]            off_r, off_nxt;
  logic                   add_r, add_nxt;
  logic [31:0]            cand_r, cand_nxt;
  logic [BUF_CW-1:0]      idx_r, idx_nxt;
  logic [EV_CW-1:0]       ev_r, ev_nxt;
  logic [EV_AW-1:0]       pev_r, pev_nxt;

  // Output register.
  logic [31:0]            out_offset_r, out_offset_nxt;
  logic [31:0]            out_arena_r, out_arena_nxt;
  logic [31:0]            out_peak_r, out_peak_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;

  // Buffer table RAM: offset, aligned end, live interval and alias mark.
  logic                   tab_we;
  logic [BUF_AW-1:0]      tab_waddr;
  entry_t                 tab_wdata;
  logic [BUF_AW-1:0]      tab_raddr;
  logic [$bits(entry_t)-1:0] tab_rdata_raw;
  entry_t                 tab_rd;

  // Event sum RAM; an entry without its valid bit reads as zero.
  logic                   sum_we;
  logic [31:0]            sum_rdata;
  logic [31:0]            sum_old;
  logic [32:0]            sum_add;
  logic [31:0]            sum_new;
  logic                   ev_hit;

  // Scan datapath.
  logic [BUF_CW-1:0]      eff_cnt;
  logic                   meet;
  logic                   collide;
  logic [32:0]            cand_end;

  ffia_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BUFFERS)
  ) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata_raw)
  );

  ffia_ram #(
    .WIDTH (32),
    .DEPTH (MAX_EVENTS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (pev_r),
    .wdata (sum_new),
    .raddr (ev_r[EV_AW-1:0]),
    .rdata (sum_rdata)
  );

  assign tab_rd = entry_t'(tab_rdata_raw);

  // The candidate end is the one wide add of the scan; it is compared with
  // the stored entry's offset to find an overlap of the aligned extents.
  assign cand_end = {1'b0, cand_r} + need_r;
  assign meet     = !((le_r < tab_rd.first_ev) || (tab_rd.last_ev < fe_r));
  assign collide  = chk_vld_r && !tab_rd.is_alias && meet &&
                    (cand_r < tab_rd.end_addr) &&
                    (cand_end > {1'b0, tab_rd.offset});

  // Event sum update: saturating add of the raw size inside the interval.
  assign sum_old = sum_vld_r[pev_r] ? sum_rdata : 32'd0;
  assign ev_hit  = add_r && (32'(pev_r) >= 32'(fe_r)) && (32'(pev_r) <= 32'(le_r));
  assign sum_add = {1'b0, sum_old} + {1'b0, size_r};
  assign sum_new = !ev_hit ? sum_old : (sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0]);

  assign eff_cnt = in_ch.start_schedule ? '0 : cnt_r;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.offset    = out_offset_r;
  assign out_ch.arena_top = out_arena_r;
  assign out_ch.live_peak = out_peak_r;
  assign out_ch.status    = out_status_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    arena_nxt       = arena_r;
    peak_nxt        = peak_r;
    event_count_nxt = event_count_r;
    sum_vld_nxt     = sum_vld_r;
    chk_vld_nxt     = chk_vld_r;
    pev_vld_nxt     = pev_vld_r;
    out_valid_nxt   = out_valid_r;
    size_nxt        = size_r;
    fe_nxt          = fe_r;
    le_nxt          = le_r;
    need_nxt        = need_r;
    status_nxt      = status_r;
    off_nxt         = off_r;
    add_nxt         = add_r;
    cand_nxt        = cand_r;
    idx_nxt         = idx_r;
    ev_nxt          = ev_r;
    pev_nxt         = pev_r;
    out_offset_nxt  = out_offset_r;
    out_arena_nxt   = out_arena_r;
    out_peak_nxt    = out_peak_r;
    out_status_nxt  = out_status_r;
    tab_we          = 1'b0;
    tab_waddr       = cnt_r[BUF_AW-1:0];
    tab_wdata       = '0;
    tab_raddr       = idx_r[BUF_AW-1:0];
    sum_we          = 1'b0;

    if (cfg_we) begin
      event_count_nxt = cfg_wdata;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          // A start flag empties the schedule before this word is handled.
          if (in_ch.start_schedule) begin
            cnt_nxt     = '0;
            arena_nxt   = '0;
            sum_vld_nxt = '0;
          end
          size_nxt    = in_ch.size_bytes;
          fe_nxt      = in_ch.first_event;
          le_nxt      = in_ch.last_event;
          need_nxt    = aligned_len(in_ch.size_bytes);
          status_nxt  = ST_OK;
          off_nxt     = '0;
          add_nxt     = 1'b0;
          cand_nxt    = '0;
          idx_nxt     = '0;
          chk_vld_nxt = 1'b0;
          ev_nxt      = '0;
          pev_vld_nxt = 1'b0;
          peak_nxt    = '0;
          if (32'(eff_cnt) >= 32'(MAX_BUFFERS)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_SWEEP;
          end else if (in_ch.is_alias) begin
            if (32'(in_ch.alias_index) >= 32'(eff_cnt)) begin
              status_nxt = ST_BAD_ALIAS;
              state_nxt  = S_SWEEP;
            end else begin
              tab_raddr = BUF_AW'(in_ch.alias_index);
              state_nxt = S_ALIAS;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_ALIAS: begin
        // The aliased entry already holds its final offset.
        off_nxt            = tab_rd.offset;
        tab_we             = 1'b1;
        tab_wdata.offset   = tab_rd.offset;
        tab_wdata.end_addr = '0;
        tab_wdata.first_ev = fe_r;
        tab_wdata.last_ev  = le_r;
        tab_wdata.is_alias = 1'b1;
        cnt_nxt            = cnt_r + 1'b1;
        state_nxt          = S_SWEEP;
      end

      S_SCAN: begin
        // One entry is read per cycle and checked in the next. A collision
        // moves the candidate past that entry and restarts from entry zero,
        // dropping the read already in flight.
        if (collide) begin
          cand_nxt    = tab_rd.end_addr;
          idx_nxt     = '0;
          chk_vld_nxt = 1'b0;
        end else if (idx_r < cnt_r) begin
          tab_raddr   = idx_r[BUF_AW-1:0];
          chk_vld_nxt = 1'b1;
          idx_nxt     = idx_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            // A full pass without collision: the candidate is the offset, unless its end overflows 32 bits.
            if (cand_end[32]) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              off_nxt            = cand_r;
              tab_we             = 1'b1;
              tab_wdata.offset   = cand_r;
              tab_wdata.end_addr = cand_end[31:0];
              tab_wdata.first_ev = fe_r;
              tab_wdata.last_ev  = le_r;
              tab_wdata.is_alias = 1'b0;
              cnt_nxt            = cnt_r + 1'b1;
              add_nxt            = 1'b1;
              if (cand_end[31:0] > arena_r) begin
                arena_nxt = cand_end[31:0];
              end
            end
            state_nxt = S_SWEEP;
          end
        end
      end

      S_SWEEP: begin
        // Read event ev_r while writing back event pev_r, one event a cycle.
        // The peak only looks at events below event_count.
        if (32'(ev_r) < 32'(MAX_EVENTS)) begin
          pev_nxt     = ev_r[EV_AW-1:0];
          pev_vld_nxt = 1'b1;
          ev_nxt      = ev_r + 1'b1;
        end else begin
          pev_vld_nxt = 1'b0;
        end
        if (pev_vld_r) begin
          sum_we             = 1'b1;
          sum_vld_nxt[pev_r] = 1'b1;
          if ((32'(pev_r) < 32'(event_count_r)) && (sum_new > peak_r)) begin
            peak_nxt = sum_new;
          end
        end else if (32'(ev_r) >= 32'(MAX_EVENTS)) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_offset_nxt = off_r;
          out_arena_nxt  = arena_r;
          out_peak_nxt   = peak_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      arena_r       <= '0;
      peak_r        <= '0;
      event_count_r <= EVENT_COUNT_RST;
      sum_vld_r     <= '0;
      chk_vld_r     <= 1'b0;
      pev_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      arena_r       <= arena_nxt;
      peak_r        <= peak_nxt;
      event_count_r <= event_count_nxt;
      sum_vld_r     <= sum_vld_nxt;
      chk_vld_r     <= chk_vld_nxt;
      pev_vld_r     <= pev_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    fe_r         <= fe_nxt;
    le_r         <= le_nxt;
    need_r       <= need_nxt;
    status_r     <= status_nxt;
    off_r        <= off_nxt;
    add_r        <= add_nxt;
    cand_r       <= cand_nxt;
    idx_r        <= idx_nxt;
    ev_r         <= ev_nxt;
    pev_r        <= pev_nxt;
    out_offset_r <= out_offset_nxt;
    out_arena_r  <= out_arena_nxt;
    out_peak_r   <= out_peak_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ----- rtl/core/ffia_chk.sv -----
// ----------------------------------------------------------------------------
// ffia_chk: port-level checks of the first-fit arena layout block
// Watches the handshakes and result words and is bound to the top level.
// ----------------------------------------------------------------------------
module ffia_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_offset,
  input logic [31:0] out_arena_top,
  input logic [31:0] out_live_peak,
  input logic [1:0]  out_status
);

  import ffia_pkg::*;

  // The block works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is still in work");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_offset) &&
      $stable(out_arena_top) && $stable(out_live_peak) && $stable(out_status)))
    else $error("stalled result word changed");

  // A rejected word reports offset zero.
  a_reject_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_offset == 32'd0))
    else $error("rejected word with a nonzero offset");

  // Every offset lies inside the arena placed so far.
  a_offset_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_offset <= out_arena_top))
    else $error("offset beyond the arena end");

endmodule

bind first_fit_interval_arena_layout ffia_chk u_ffia_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_offset    (out_ch.offset),
  .out_arena_top (out_ch.arena_top),
  .out_live_peak (out_ch.live_peak),
  .out_status    (out_ch.status)
);
